// ----- design/ptn_pkg.sv -----
// Shared constants, types and state encoding for the pulse trace normalizer.
// No dependencies; used by ptn_div, ptn_window and pulse_trace_normalizer.
package ptn_pkg;

  // Word field widths
  localparam int SAMPLE_W   = 18;
  localparam int TRACE_W    = 25;
  localparam int LEVEL_W    = 8;
  localparam int RANGE_W    = 32;
  localparam int FRAC_BITS  = 16;

  // Trace scaling
  localparam int TRACE_GAIN   = 140;
  localparam int TRACE_MARGIN = 25;
  localparam int GAIN_W       = 8;
  localparam int PLOT_OFFSET  = 30;

  // Window bookkeeping
  localparam int WINDOW_LEN = 100;
  localparam int CNT_W      = $clog2(WINDOW_LEN);

  // Divider sizes: delta * gain << fraction bits
  localparam int DIVIDEND_W = SAMPLE_W + GAIN_W + FRAC_BITS;
  localparam int STEP_W     = $clog2(DIVIDEND_W);
  localparam int WIDE_W     = DIVIDEND_W + 2;
  localparam int IPART_W    = TRACE_W - FRAC_BITS;

  // Reset values and clamp limits
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = {SAMPLE_W{1'b1}};
  localparam logic [RANGE_W-1:0]  RANGE_RESET = 32'hFFFC_0001;
  localparam logic signed [TRACE_W-1:0] TRACE_LO =
    TRACE_W'(-TRACE_MARGIN * (2 ** FRAC_BITS));
  localparam logic signed [TRACE_W-1:0] TRACE_HI =
    TRACE_W'((TRACE_GAIN + TRACE_MARGIN) * (2 ** FRAC_BITS));

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ptn_div_stat_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } ptn_state_e;

endpackage

// ----- design/ptn_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on ptn_pkg for widths and the status struct.
module ptn_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ptn_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [ptn_pkg::RANGE_W-1:0]      divisor_i,
  output ptn_pkg::ptn_div_stat_t           stat_o,
  output logic [ptn_pkg::DIVIDEND_W-1:0]   quotient_o
);

  localparam int DW = ptn_pkg::DIVIDEND_W;
  localparam int RW = ptn_pkg::RANGE_W;
  localparam int SW = ptn_pkg::STEP_W;

  logic          run_q, run_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] div_q, div_d;
  logic [RW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;

  logic [RW:0]   rem_sh;
  logic [RW+1:0] diff;
  logic          ge;
  logic          last;

  // Shared subtractor: trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh = {rem_q[RW-1:0], quo_q[DW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_q};
    ge     = ~diff[RW+1];
    last   = (cnt_q == SW'(DW - 1));
  end

  // Step sequencing
  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    div_d = div_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      div_d = divisor_i;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? diff[RW:0] : rem_sh;
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + SW'(1);
      if (last) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = run_q & last;
  assign quotient_o  = quo_q;

endmodule

// ----- design/ptn_window.sv -----
// Window min/max tracker; yields the range used by the next window.
// Depends on ptn_pkg for widths, window length and reset values.
module ptn_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  logic [ptn_pkg::SAMPLE_W-1:0]  sample_i,
  output logic [ptn_pkg::RANGE_W-1:0]   range_o,
  output logic                          closed_o
);

  localparam int SW = ptn_pkg::SAMPLE_W;
  localparam int CW = ptn_pkg::CNT_W;

  logic [SW-1:0]                min_q, min_d, max_q, max_d;
  logic [SW-1:0]                new_min, new_max;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [ptn_pkg::RANGE_W-1:0]  range_q, range_d;
  logic                         closed_q, closed_d;

  // Fold in the sample, close the window on its last word
  always_comb begin
    new_min  = (sample_i < min_q) ? sample_i : min_q;
    new_max  = (sample_i > max_q) ? sample_i : max_q;
    min_d    = min_q;
    max_d    = max_q;
    cnt_d    = cnt_q;
    range_d  = range_q;
    closed_d = closed_q;
    if (upd_i) begin
      if (cnt_q == CW'(ptn_pkg::WINDOW_LEN - 1)) begin
        range_d  = ptn_pkg::RANGE_W'(new_max - new_min);
        min_d    = ptn_pkg::SAMPLE_MAX;
        max_d    = '0;
        cnt_d    = '0;
        closed_d = 1'b1;
      end else begin
        min_d    = new_min;
        max_d    = new_max;
        cnt_d    = cnt_q + CW'(1);
        closed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= ptn_pkg::SAMPLE_MAX;
      max_q    <= '0;
      cnt_q    <= '0;
      range_q  <= ptn_pkg::RANGE_RESET;
      closed_q <= 1'b0;
    end else begin
      min_q    <= min_d;
      max_q    <= max_d;
      cnt_q    <= cnt_d;
      range_q  <= range_d;
      closed_q <= closed_d;
    end
  end

  assign range_o  = range_q;
  assign closed_o = closed_q;

endmodule

// ----- design/pulse_trace_normalizer.sv -----
// Top level of the pulse trace normalizer: sequencer, trace update, output register.
// Depends on ptn_pkg, ptn_div and ptn_window.

// Each accepted sample word yields one result word. The step is
// |sample - previous| * 140 * 2^16 divided by the previous window's range,
// computed by a bit-serial divider. The sequencer goes from S_IDLE through
// S_DIV to S_DONE, where the updated trace is loaded into the output register,
// and then back to S_IDLE, where the next word can be accepted. When the
// range is zero the divider is skipped: the sequencer goes from S_IDLE
// straight to S_DONE and the trace holds.
// in_ready_o is low while a word is in work. A finished result sits in the
// output register while the next word is taken; the update of that next word
// waits until the register has been emptied. trace_o is signed with 16
// fraction bits, clamped to -25..165; the range updates every 100 samples.
module pulse_trace_normalizer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ptn_pkg::SAMPLE_W-1:0]         sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ptn_pkg::TRACE_W-1:0]   trace_o,
  output logic [ptn_pkg::LEVEL_W-1:0]          plot_level_o,
  output logic                                 window_end_o
);

  localparam int SW = ptn_pkg::SAMPLE_W;
  localparam int TW = ptn_pkg::TRACE_W;
  localparam int DW = ptn_pkg::DIVIDEND_W;
  localparam int WW = ptn_pkg::WIDE_W;
  localparam int IW = ptn_pkg::IPART_W;
  localparam int FB = ptn_pkg::FRAC_BITS;

  ptn_pkg::ptn_state_e state_q, state_d;

  logic                    accept;
  logic                    load_out;
  logic                    div_start;
  logic [SW-1:0]           prev_q;
  logic                    rise_q;
  logic                    skip_q;
  logic                    rise_now;
  logic [SW-1:0]           delta;
  logic [DW-1:0]           dividend;
  logic [ptn_pkg::RANGE_W-1:0] range;
  logic                    closed;
  ptn_pkg::ptn_div_stat_t  div_stat;
  logic [DW-1:0]           quotient;

  logic signed [TW-1:0]    trace_q, trace_d;
  logic signed [WW-1:0]    trace_ext, step_ext, sum;
  logic signed [IW-1:0]    ipart;
  logic [IW-1:0]           level_w;
  logic [ptn_pkg::LEVEL_W-1:0] level_d, level_q;
  logic                    out_valid_q, win_end_q;

  assign accept   = in_valid_i & in_ready_o;
  assign load_out = (state_q == ptn_pkg::S_DONE) & (~out_valid_q | out_ready_i);

  // Step numerator from the sample change
  always_comb begin
    rise_now  = (sample_i > prev_q);
    delta     = rise_now ? (sample_i - prev_q) : (prev_q - sample_i);
    dividend  = (DW'(delta) * DW'(ptn_pkg::TRACE_GAIN)) << FB;
    div_start = accept & (range != '0);
  end

  ptn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (range),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  ptn_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (accept),
    .sample_i (sample_i),
    .range_o  (range),
    .closed_o (closed)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ptn_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = (range == '0) ? ptn_pkg::S_DONE : ptn_pkg::S_DIV;
      end
      ptn_pkg::S_DIV: begin
        if (div_stat.done) state_d = ptn_pkg::S_DONE;
      end
      ptn_pkg::S_DONE: begin
        if (load_out) state_d = ptn_pkg::S_IDLE;
      end
      default: state_d = ptn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ptn_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // Trace update with clamp, then integer part toward zero plus offset
  always_comb begin
    trace_ext = WW'(trace_q);
    step_ext  = skip_q ? '0 : signed'({2'b00, quotient});
    if (rise_q) begin
      sum = trace_ext - step_ext;
      if (sum < WW'(ptn_pkg::TRACE_LO)) sum = WW'(ptn_pkg::TRACE_LO);
    end else begin
      sum = trace_ext + step_ext;
      if (sum > WW'(ptn_pkg::TRACE_HI)) sum = WW'(ptn_pkg::TRACE_HI);
    end
    trace_d = sum[TW-1:0];
    ipart   = trace_d[TW-1:FB];
    level_w = ipart + IW'(trace_d[TW-1] & (|trace_d[FB-1:0]))
              + IW'(ptn_pkg::PLOT_OFFSET);
    level_d = level_w[ptn_pkg::LEVEL_W-1:0];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      trace_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) prev_q <= sample_i;
      if (load_out) begin
        trace_q     <= trace_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-word flags and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rise_q <= rise_now;
      skip_q <= (range == '0);
    end
    if (load_out) begin
      level_q   <= level_d;
      win_end_q <= closed;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign trace_o      = trace_q;
  assign plot_level_o = level_q;
  assign window_end_o = win_end_q;

endmodule

// ----- tb/sv/pulse_trace_normalizer_tb.sv -----
// Self-checking testbench for pulse_trace_normalizer: random valid/ready traffic on both
// sides, predicted trace words kept in a small scoreboard class and compared field by field.
// Depends on ptn_pkg and the pulse_trace_normalizer RTL.
`timescale 1ns / 100ps

module pulse_trace_normalizer_tb;

  localparam int RANDOM_WORDS = 1380;

  // Shape of the samples inside one window
  typedef enum int {
    W_FLAT,
    W_NARROW,
    W_FULL,
    W_WALK,
    W_EDGE,
    W_SMALL
  } win_mode_e;

  typedef struct {
    logic signed [ptn_pkg::TRACE_W-1:0] trace;
    logic [ptn_pkg::LEVEL_W-1:0]        level;
    logic                               win_end;
  } trace_word_t;

  // Trace predictor plus queue of expected result words
  class trace_board;
    trace_word_t                  expected_q[$];
    logic [ptn_pkg::SAMPLE_W-1:0] last_sample;
    longint                       trace_acc;
    logic [ptn_pkg::RANGE_W-1:0]  span;
    logic [ptn_pkg::SAMPLE_W-1:0] win_lo;
    logic [ptn_pkg::SAMPLE_W-1:0] win_hi;
    int                           win_pos;
    int                           errors;
    int                           n_samples;
    int                           n_windows;
    int                           n_clamps;
    int                           n_flat;

    function new();
      last_sample = '0;
      trace_acc   = 0;
      span        = ptn_pkg::RANGE_RESET;
      win_lo      = ptn_pkg::SAMPLE_MAX;
      win_hi      = '0;
      win_pos     = 0;
      errors      = 0;
      n_samples   = 0;
      n_windows   = 0;
      n_clamps    = 0;
      n_flat      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // |delta| * gain * 2^frac / range, truncated
    function longint unsigned scaled_step(logic [ptn_pkg::SAMPLE_W-1:0] delta);
      return ((64'(delta) * ptn_pkg::TRACE_GAIN) << ptn_pkg::FRAC_BITS) / 64'(span);
    endfunction

    // Accepted sample word: advance the predicted state, queue the result
    function void take_sample(logic [ptn_pkg::SAMPLE_W-1:0] s);
      longint      lo_lim;
      longint      hi_lim;
      longint      whole;
      trace_word_t w;
      lo_lim = longint'(ptn_pkg::TRACE_LO);
      hi_lim = longint'(ptn_pkg::TRACE_HI);
      n_samples++;
      // zero range: trace holds
      if (span == '0) begin
        n_flat++;
      end else if (s > last_sample) begin
        trace_acc -= longint'(scaled_step(s - last_sample));
        if (trace_acc < lo_lim) begin
          trace_acc = lo_lim;
          n_clamps++;
        end
      end else begin
        // equal samples take this path too
        trace_acc += longint'(scaled_step(last_sample - s));
        if (trace_acc > hi_lim) begin
          trace_acc = hi_lim;
          n_clamps++;
        end
      end
      last_sample = s;

      // window bookkeeping, new range applies from the next sample
      if (s < win_lo) win_lo = s;
      if (s > win_hi) win_hi = s;
      if (win_pos + 1 >= ptn_pkg::WINDOW_LEN) begin
        span      = ptn_pkg::RANGE_W'(win_hi - win_lo);
        win_lo    = ptn_pkg::SAMPLE_MAX;
        win_hi    = '0;
        win_pos   = 0;
        w.win_end = 1'b1;
        n_windows++;
      end else begin
        win_pos++;
        w.win_end = 1'b0;
      end

      whole   = trace_acc / (longint'(1) << ptn_pkg::FRAC_BITS);
      w.trace = ptn_pkg::TRACE_W'(trace_acc);
      w.level = ptn_pkg::LEVEL_W'(whole + ptn_pkg::PLOT_OFFSET);
      expected_q.push_back(w);
    endfunction

    task report(string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    // Accepted result word against the oldest expectation
    task compare_result(logic signed [ptn_pkg::TRACE_W-1:0] tr,
                        logic [ptn_pkg::LEVEL_W-1:0] lv, logic we);
      trace_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with none expected, trace %0d", tr));
        return;
      end
      w = expected_q.pop_front();
      if (tr !== w.trace)
        report($sformatf("trace %0d, expected %0d", tr, w.trace));
      if (lv !== w.level)
        report($sformatf("plot_level %0d, expected %0d", lv, w.level));
      if (we !== w.win_end)
        report($sformatf("window_end %0b, expected %0b", we, w.win_end));
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic [ptn_pkg::SAMPLE_W-1:0]       sample_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [ptn_pkg::TRACE_W-1:0] trace_o;
  logic [ptn_pkg::LEVEL_W-1:0]        plot_level_o;
  logic                               window_end_o;

  trace_board                   board;
  bit                           idle_on = 1'b1;
  win_mode_e                    mode = W_FULL;
  logic [ptn_pkg::SAMPLE_W-1:0] base = '0;
  int                           narrow_span = 1;
  int                           walk_pos = 131072;

  pulse_trace_normalizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .trace_o      (trace_o),
    .plot_level_o (plot_level_o),
    .window_end_o (window_end_o)
  );

  always #5 clk_i = ~clk_i;

  // New window shape and idling choice
  task pick_mode();
    case ($urandom_range(0, 9))
      0, 1:    mode = W_FLAT;
      2, 3:    mode = W_NARROW;
      4, 5:    mode = W_FULL;
      6:       mode = W_WALK;
      7:       mode = W_EDGE;
      default: mode = W_SMALL;
    endcase
    narrow_span = $urandom_range(1, 3);
    base        = ptn_pkg::SAMPLE_W'($urandom_range(0, int'(ptn_pkg::SAMPLE_MAX) - 255));
    idle_on     = ($urandom_range(0, 3) != 0);
  endtask

  function automatic logic [ptn_pkg::SAMPLE_W-1:0] next_value();
    int pos;
    case (mode)
      W_FLAT:   return base;
      W_NARROW: return base + ptn_pkg::SAMPLE_W'($urandom_range(0, narrow_span));
      W_WALK: begin
        pos = walk_pos + int'($urandom_range(0, 4000)) - 2000;
        if (pos < 0) pos = 0;
        if (pos > int'(ptn_pkg::SAMPLE_MAX)) pos = int'(ptn_pkg::SAMPLE_MAX);
        walk_pos = pos;
        return ptn_pkg::SAMPLE_W'(pos);
      end
      W_EDGE:   return $urandom_range(0, 1) ? ptn_pkg::SAMPLE_MAX : '0;
      W_SMALL:  return base + ptn_pkg::SAMPLE_W'($urandom_range(0, 255));
      default:  return ptn_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  // Send one sample word; hold_off waits for all results first
  task push_sample(input logic [ptn_pkg::SAMPLE_W-1:0] s, input bit hold_off);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (hold_off && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (hold_off) while (board.pending() != 0) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.take_sample(s);
  endtask

  // Stimulus and end of run
  initial begin
    logic [ptn_pkg::SAMPLE_W-1:0] directed[16];
    board    = new();
    // equal at reset, full swings, off-by-one, alternating bits
    directed = '{'0, ptn_pkg::SAMPLE_MAX, '0, '0, ptn_pkg::SAMPLE_MAX,
                 ptn_pkg::SAMPLE_MAX, 18'd1, 18'h3FFFE, 18'h2AAAA, 18'h15555,
                 18'h20000, 18'h1FFFF, '0, 18'd1, ptn_pkg::SAMPLE_MAX, 18'h3FFFE};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) push_sample(directed[i], 1'b0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (board.win_pos == 0) pick_mode();
      push_sample(next_value(), i == RANDOM_WORDS / 2);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d samples through %0d window ends with random stalls on both sides;",
             board.n_samples, board.n_windows);
    $display("%0d steps hit a clamp, %0d samples fell on a zero range.",
             board.n_clamps, board.n_flat);
    if (board.errors == 0) begin
      $display("pulse_trace_normalizer: match");
    end else begin
      $display("pulse_trace_normalizer: mismatch");
    end
    $finish;
  end

  // Result side: random stall before each word, then hold ready
  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.compare_result(trace_o, plot_level_o, window_end_o);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("pulse_trace_normalizer: mismatch");
    $finish;
  end

endmodule
